### rtl/cle_pkg.sv
package cle_pkg;

  // Field widths of the item and result payloads
  localparam int KEY_W      = 8;
  localparam int IDX_W      = 10;
  localparam int LEN_W      = 11;
  localparam int CFG_IDX_W  = 3;

  localparam int LINE_CAPACITY_DEF = 1024;

  localparam logic [KEY_W-1:0] ECHO_NEWLINE_CODE = 8'hFF;
  localparam logic [KEY_W-1:0] ECHO_BLOCKED_CODE = 8'h00;

  // Key register reset values
  localparam logic [KEY_W-1:0] NEWLINE_KEY_RST   = 8'd10;
  localparam logic [KEY_W-1:0] BACKSPACE_KEY_RST = 8'd8;
  localparam logic [KEY_W-1:0] DELETE_KEY_RST    = 8'd127;
  localparam logic [KEY_W-1:0] LEFT_KEY_RST      = 8'd128;
  localparam logic [KEY_W-1:0] RIGHT_KEY_RST     = 8'd129;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKSPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELETE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT     = 3'd4;

  // Item operation codes
  localparam logic OP_EDIT = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key_code;
    logic [IDX_W-1:0] read_index;
  } cle_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] echo_code;
    logic [LEN_W-1:0] line_length;
    logic [LEN_W-1:0] cursor_position;
    logic [KEY_W-1:0] read_char;
  } cle_out_t;

  typedef enum logic [2:0] {
    KIND_NEWLINE,
    KIND_BACKSPACE,
    KIND_DELETE,
    KIND_LEFT,
    KIND_RIGHT,
    KIND_INSERT
  } cle_kind_e;

  typedef enum logic [1:0] {
    ECHO_ZERO,
    ECHO_NEWLINE,
    ECHO_KEY
  } cle_echo_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REMOVE,
    ST_SHIFT,
    ST_DRAIN,
    ST_FILL,
    ST_RESP
  } cle_state_e;

  // Controller to datapath
  typedef struct packed {
    logic      load_item;
    logic      issue_read;
    logic      echo_ld;
    cle_echo_e echo_sel;
    logic      cur_dec;
    logic      cur_inc;
    logic      mode_ld;
    logic      mode_ins;
    logic      shift_init;
    logic      shift_step;
    logic      fill_write;
    logic      out_load;
  } cle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic      is_read;
    cle_kind_e kind;
    logic      cur_zero;
    logic      at_end;
    logic      full;
    logic      has_tail;
    logic      ptr_last;
    logic      out_free;
  } cle_stat_t;

endpackage

### rtl/cle_ctrl.sv
module cle_ctrl
  import cle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  cle_stat_t stat_i,
  output cle_cmd_t  cmd_o
);

  cle_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.echo_ld = 1'b1;
        state_d       = ST_RESP;
        if (stat_i.is_read) begin
          cmd_o.issue_read = 1'b1;
          cmd_o.echo_sel   = ECHO_ZERO;
        end else begin
          case (stat_i.kind)
            KIND_NEWLINE: begin
              cmd_o.echo_sel = ECHO_NEWLINE;
            end
            KIND_BACKSPACE: begin
              if (stat_i.cur_zero) begin
                cmd_o.echo_sel = ECHO_ZERO;
              end else begin
                cmd_o.echo_sel = ECHO_KEY;
                cmd_o.cur_dec  = 1'b1;
                cmd_o.mode_ld  = 1'b1;
                state_d        = ST_REMOVE;
              end
            end
            KIND_DELETE: begin
              if (stat_i.at_end) begin
                cmd_o.echo_sel = ECHO_ZERO;
              end else begin
                cmd_o.echo_sel = ECHO_KEY;
                cmd_o.mode_ld  = 1'b1;
                state_d        = ST_REMOVE;
              end
            end
            KIND_LEFT: begin
              if (stat_i.cur_zero) begin
                cmd_o.echo_sel = ECHO_ZERO;
              end else begin
                cmd_o.echo_sel = ECHO_KEY;
                cmd_o.cur_dec  = 1'b1;
              end
            end
            KIND_RIGHT: begin
              if (stat_i.at_end) begin
                cmd_o.echo_sel = ECHO_ZERO;
              end else begin
                cmd_o.echo_sel = ECHO_KEY;
                cmd_o.cur_inc  = 1'b1;
              end
            end
            default: begin
              // insert; a full line drops the key but still echoes it
              cmd_o.echo_sel = ECHO_KEY;
              cmd_o.mode_ins = 1'b1;
              if (!stat_i.full) begin
                cmd_o.mode_ld = 1'b1;
                if (stat_i.at_end) begin
                  state_d = ST_FILL;
                end else begin
                  cmd_o.shift_init = 1'b1;
                  state_d          = ST_SHIFT;
                end
              end
            end
          endcase
        end
      end
      ST_REMOVE: begin
        if (stat_i.has_tail) begin
          cmd_o.shift_init = 1'b1;
          state_d          = ST_SHIFT;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (stat_i.ptr_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.fill_write = 1'b1;
        state_d          = ST_RESP;
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && !stat_i.ptr_last) |=> (state_q == ST_SHIFT))
    else $error("shift left before reaching the last entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> (state_q == ST_FILL))
    else $error("drain not followed by fill");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |=> (state_q == ST_EXEC))
    else $error("accepted item not executed");

endmodule

### rtl/cle_dpath.sv
module cle_dpath
  import cle_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cle_in_t              in_item_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KEY_W-1:0]     cfg_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output cle_out_t             out_item_o,
  input  cle_cmd_t             cmd_i,
  output cle_stat_t            stat_o
);

  localparam int AW = $clog2(LINE_CAPACITY);
  localparam int LW = $clog2(LINE_CAPACITY + 1);

  logic [KEY_W-1:0] nl_key_q, bs_key_q, del_key_q, left_key_q, right_key_q;

  cle_in_t          item_q;
  logic [LW-1:0]    length_q, cursor_q;
  logic             mode_ins_q;
  logic [KEY_W-1:0] echo_q;
  logic             rd_ok_q;

  logic [AW-1:0]    ptr_q, end_q, dst_q;
  logic             pend_q;

  logic [KEY_W-1:0] mem [LINE_CAPACITY];
  logic [KEY_W-1:0] rdata_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [KEY_W-1:0] mem_wdata;

  logic             out_valid_q;
  cle_out_t         out_q;

  logic [LW-1:0]    len_m1;
  logic             idx_in_range;
  cle_kind_e        kind;

  assign len_m1       = length_q - LW'(1);
  assign idx_in_range = 32'(item_q.read_index) < LINE_CAPACITY;

  // Match order: newline, backspace, delete, left, right
  always_comb begin
    if (item_q.key_code == nl_key_q) begin
      kind = KIND_NEWLINE;
    end else if (item_q.key_code == bs_key_q) begin
      kind = KIND_BACKSPACE;
    end else if (item_q.key_code == del_key_q) begin
      kind = KIND_DELETE;
    end else if (item_q.key_code == left_key_q) begin
      kind = KIND_LEFT;
    end else if (item_q.key_code == right_key_q) begin
      kind = KIND_RIGHT;
    end else begin
      kind = KIND_INSERT;
    end
  end

  assign stat_o.is_read  = (item_q.op == OP_READ);
  assign stat_o.kind     = kind;
  assign stat_o.cur_zero = (cursor_q == '0);
  assign stat_o.at_end   = (cursor_q == length_q);
  assign stat_o.full     = (32'(length_q) >= LINE_CAPACITY);
  assign stat_o.has_tail = (cursor_q < len_m1);
  assign stat_o.ptr_last = (ptr_q == end_q);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_key_q    <= NEWLINE_KEY_RST;
      bs_key_q    <= BACKSPACE_KEY_RST;
      del_key_q   <= DELETE_KEY_RST;
      left_key_q  <= LEFT_KEY_RST;
      right_key_q <= RIGHT_KEY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NEWLINE:   nl_key_q    <= cfg_data_i;
        CFG_BACKSPACE: bs_key_q    <= cfg_data_i;
        CFG_DELETE:    del_key_q   <= cfg_data_i;
        CFG_LEFT:      left_key_q  <= cfg_data_i;
        CFG_RIGHT:     right_key_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Line length, cursor and shift control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q   <= '0;
      cursor_q   <= '0;
      mode_ins_q <= 1'b0;
      pend_q     <= 1'b0;
      rd_ok_q    <= 1'b0;
    end else begin
      if (cmd_i.load_item) begin
        rd_ok_q <= 1'b0;
      end else if (cmd_i.issue_read) begin
        rd_ok_q <= idx_in_range;
      end
      if (cmd_i.mode_ld) begin
        mode_ins_q <= cmd_i.mode_ins;
      end
      if (cmd_i.cur_dec) begin
        cursor_q <= cursor_q - LW'(1);
      end else if (cmd_i.cur_inc) begin
        cursor_q <= cursor_q + LW'(1);
      end
      if (cmd_i.fill_write) begin
        if (mode_ins_q) begin
          cursor_q <= cursor_q + LW'(1);
          length_q <= length_q + LW'(1);
        end else begin
          length_q <= len_m1;
        end
      end
      pend_q <= cmd_i.shift_step;
    end
  end

  // Item, echo and shift pointer registers; the pointer walks down for insert, up for removal
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
    if (cmd_i.echo_ld) begin
      case (cmd_i.echo_sel)
        ECHO_NEWLINE: echo_q <= ECHO_NEWLINE_CODE;
        ECHO_KEY:     echo_q <= item_q.key_code;
        default:      echo_q <= ECHO_BLOCKED_CODE;
      endcase
    end
    if (cmd_i.shift_init) begin
      if (cmd_i.mode_ins) begin
        ptr_q <= AW'(len_m1);
        end_q <= AW'(cursor_q);
      end else begin
        ptr_q <= AW'(cursor_q) + AW'(1);
        end_q <= AW'(len_m1);
      end
    end else if (cmd_i.shift_step) begin
      ptr_q <= mode_ins_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
      dst_q <= mode_ins_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
    end
  end

  // One read and one write port; a shift read issued in one cycle is written back
  // to its destination in the next
  always_comb begin
    mem_re    = cmd_i.shift_step || (cmd_i.issue_read && idx_in_range);
    mem_raddr = cmd_i.shift_step ? ptr_q : AW'(item_q.read_index);
    mem_we    = pend_q || cmd_i.fill_write;
    if (pend_q) begin
      mem_waddr = dst_q;
      mem_wdata = rdata_q;
    end else if (mode_ins_q) begin
      mem_waddr = AW'(cursor_q);
      mem_wdata = item_q.key_code;
    end else begin
      mem_waddr = AW'(len_m1);
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.echo_code       <= echo_q;
      out_q.line_length     <= LEN_W'(length_q);
      out_q.cursor_position <= LEN_W'(cursor_q);
      out_q.read_char       <= rd_ok_q ? rdata_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= length_q)
    else $error("cursor beyond line end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(length_q) <= LINE_CAPACITY)
    else $error("line length above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_write |-> !pend_q)
    else $error("fill write collides with shift write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule

### rtl/console_line_editor.sv
// Console line editor: a line of characters with a length and a cursor.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): op 0 edits with
// key_code, op 1 reads the stored character at read_index. The item is
// taken when valid is high and stall is low; stall stays high while an
// item is in work, so one item is handled at a time.
// Output channel (out_valid_o / out_stall_i / out_item_o): one result per
// item with echo, line length, cursor and read character.
// Config channel (cfg_valid_i / cfg_ready_o): always ready; writes the
// newline, backspace, delete, left and right key codes at index 0..4.
// Write it only while no item is in work.
//
// Reads, newlines, cursor moves, blocked edits and inserts into a full line
// go from decode straight to the result; an insert at the line end first
// writes its character, and other inserts and removals first shift the
// tail, the characters past the cursor, then write. One character moves
// per cycle through the single read and write port of the line store.
// A result held by out_stall_i sits in the output register; the next item
// may be accepted and worked meanwhile, but its result waits until the
// held one is taken. Reset empties the line, homes the cursor and loads
// the default key codes; the line store itself is not cleared.
module console_line_editor
  import cle_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cle_in_t              in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cle_out_t             out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KEY_W-1:0]     cfg_data_i
);

  cle_cmd_t  cmd;
  cle_stat_t stat;

  // Key registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  // Sequence each item: decode, shift, fill, hand over result
  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Line store, length, cursor, key registers and output register
  cle_dpath #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

### tb/line_scoreboard_pkg.sv
`timescale 1ns / 100ps
package line_scoreboard_pkg;
  import cle_pkg::*;

  localparam int LINE_CAP = LINE_CAPACITY_DEF;
  localparam int KEY_REGS = 5;

  class line_scoreboard;
    logic [KEY_W-1:0] line_chars [LINE_CAP];
    logic [KEY_W-1:0] key_reg [KEY_REGS];
    int unsigned      line_len;
    int unsigned      cursor_pos;
    // Entries below this have been written at least once and may be read.
    int unsigned      written_span;
    cle_out_t         expected_lines [$];

    int unsigned errors, items_seen, results_seen;
    int unsigned reads, inserts, drops, removals, moves, blocked, newlines;

    function new();
      foreach (line_chars[i]) line_chars[i] = '0;
      line_len     = 0;
      cursor_pos   = 0;
      written_span = 0;
      key_reg[CFG_NEWLINE]   = NEWLINE_KEY_RST;
      key_reg[CFG_BACKSPACE] = BACKSPACE_KEY_RST;
      key_reg[CFG_DELETE]    = DELETE_KEY_RST;
      key_reg[CFG_LEFT]      = LEFT_KEY_RST;
      key_reg[CFG_RIGHT]     = RIGHT_KEY_RST;
    endfunction

    function void set_key(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] value);
      if (idx <= CFG_RIGHT) key_reg[idx] = value;
    endfunction

    // First match wins, in the order newline, backspace, delete, left, right.
    function cle_kind_e classify(logic [KEY_W-1:0] k);
      if (k == key_reg[CFG_NEWLINE])   return KIND_NEWLINE;
      if (k == key_reg[CFG_BACKSPACE]) return KIND_BACKSPACE;
      if (k == key_reg[CFG_DELETE])    return KIND_DELETE;
      if (k == key_reg[CFG_LEFT])      return KIND_LEFT;
      if (k == key_reg[CFG_RIGHT])     return KIND_RIGHT;
      return KIND_INSERT;
    endfunction

    // Close the gap at the cursor; the vacated last entry becomes zero.
    function void take_out();
      for (int unsigned i = cursor_pos; i + 1 < line_len; i++) line_chars[i] = line_chars[i + 1];
      line_chars[line_len - 1] = '0;
      line_len--;
      removals++;
    endfunction

    function void put_in(logic [KEY_W-1:0] ch);
      if (line_len >= LINE_CAP) begin
        drops++;
        return;
      end
      for (int unsigned i = line_len; i > cursor_pos; i--) line_chars[i] = line_chars[i - 1];
      line_chars[cursor_pos] = ch;
      cursor_pos++;
      line_len++;
      if (line_len > written_span) written_span = line_len;
      inserts++;
    endfunction

    function logic [KEY_W-1:0] edit_line(logic [KEY_W-1:0] k);
      case (classify(k))
        KIND_NEWLINE: begin
          newlines++;
          return ECHO_NEWLINE_CODE;
        end
        KIND_BACKSPACE: begin
          if (cursor_pos == 0) begin
            blocked++;
            return ECHO_BLOCKED_CODE;
          end
          cursor_pos--;
          take_out();
          return k;
        end
        KIND_DELETE: begin
          if (cursor_pos >= line_len) begin
            blocked++;
            return ECHO_BLOCKED_CODE;
          end
          take_out();
          return k;
        end
        KIND_LEFT: begin
          if (cursor_pos == 0) begin
            blocked++;
            return ECHO_BLOCKED_CODE;
          end
          cursor_pos--;
          moves++;
          return k;
        end
        KIND_RIGHT: begin
          if (cursor_pos >= line_len) begin
            blocked++;
            return ECHO_BLOCKED_CODE;
          end
          cursor_pos++;
          moves++;
          return k;
        end
        default: begin
          put_in(k);
          return k;
        end
      endcase
    endfunction

    function void accept_item(cle_in_t it);
      cle_out_t want;
      want = '0;
      items_seen++;
      if (it.op == OP_READ) begin
        reads++;
        if (it.read_index < LINE_CAP) want.read_char = line_chars[it.read_index];
      end else begin
        want.echo_code = edit_line(it.key_code);
      end
      want.line_length     = LEN_W'(line_len);
      want.cursor_position = LEN_W'(cursor_pos);
      expected_lines.push_back(want);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void compare_result(cle_out_t got);
      cle_out_t want;
      if (expected_lines.size() == 0) begin
        errors++;
        $display("%0t ns: result %h arrived with none outstanding", $time, got);
        return;
      end
      want = expected_lines.pop_front();
      results_seen++;
      check_field("echo_code", want.echo_code, got.echo_code);
      check_field("line_length", want.line_length, got.line_length);
      check_field("cursor_position", want.cursor_position, got.cursor_position);
      check_field("read_char", want.read_char, got.read_char);
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction
  endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import cle_pkg::*;
  import line_scoreboard_pkg::*;

  // Longest quiet stretch of a correct run: an edit at the line start moves the
  // whole line, plus a long sender gap and a long receiver stall. Take that
  // several times over.
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int IN_W           = $bits(cle_in_t);

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  cle_in_t              in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  cle_out_t             out_item_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [KEY_W-1:0]     cfg_data_i;

  line_scoreboard board;
  bit             steady;        // no gaps and no stalls while set
  int unsigned    quiet_cycles = 0;
  int unsigned    key_settings = 1;

  console_line_editor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A code that none of the five key registers claims, so it gets inserted.
  function automatic logic [KEY_W-1:0] plain_char();
    logic [KEY_W-1:0] c;
    c = KEY_W'($urandom);
    while (board.classify(c) != KIND_INSERT) c = KEY_W'($urandom);
    return c;
  endfunction

  function automatic cle_in_t key_item(logic [KEY_W-1:0] k);
    cle_in_t it;
    it.op         = OP_EDIT;
    it.key_code   = k;
    it.read_index = IDX_W'($urandom);
    return it;
  endfunction

  function automatic cle_in_t read_item(logic [IDX_W-1:0] idx);
    cle_in_t it;
    it.op         = OP_READ;
    it.key_code   = KEY_W'($urandom);
    it.read_index = idx;
    return it;
  endfunction

  // Keystroke mix: keep the line short so shifts stay cheap, favor inserts on a
  // short line and removals on a long one. Reads only touch written entries.
  function automatic cle_in_t random_keystroke();
    cle_in_t it;
    int      r;
    int      ins_w;
    r     = $urandom_range(0, 99);
    ins_w = (board.line_len < 6) ? 55 : (board.line_len < 30) ? 30 : 8;
    if (r < 6) begin
      // Raw noise item; steer reads away from never-written entries.
      it = cle_in_t'(IN_W'($urandom));
      if (it.op == OP_READ) begin
        if (board.written_span == 0) it.op = OP_EDIT;
        else if (it.read_index >= board.written_span)
          it.read_index = IDX_W'($urandom_range(0, board.written_span - 1));
      end
      return it;
    end
    if (r < 20 && board.written_span > 0)
      return read_item(IDX_W'($urandom_range(0, board.written_span - 1)));
    if (r < 25) return key_item(board.key_reg[CFG_NEWLINE]);
    if (r < 25 + ins_w) return key_item(plain_char());
    // Backspace, delete, left and right sit at consecutive indexes.
    return key_item(board.key_reg[CFG_BACKSPACE + CFG_IDX_W'($urandom_range(0, 3))]);
  endfunction

  // Present one item at the falling edge and hold it until it is taken.
  task automatic send_item(cle_in_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      in_item_i  = cle_in_t'(IN_W'($urandom));
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    board.accept_item(it);
  endtask

  // Drop valid, wait for every outstanding result, then let the block settle.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_key(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Reprogram all five keys, only once the block has gone idle.
  task automatic load_keys(logic [KEY_W-1:0] nl, logic [KEY_W-1:0] bs, logic [KEY_W-1:0] del,
                           logic [KEY_W-1:0] lf, logic [KEY_W-1:0] rt);
    drain_results();
    write_key(CFG_NEWLINE, nl);
    write_key(CFG_BACKSPACE, bs);
    write_key(CFG_DELETE, del);
    write_key(CFG_LEFT, lf);
    write_key(CFG_RIGHT, rt);
    key_settings++;
  endtask

  task automatic run_random(int count);
    repeat (count) send_item(random_keystroke());
  endtask

  // Receiver: random runs of ready, broken by stalls of the same gap profile.
  initial begin
    int run;
    int hold;
    forever begin
      run  = $urandom_range(0, 6);
      hold = pick_gap();
      out_stall_i = 1'b0;
      repeat (run + 1) @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
    end
  end

  // Check every result taken at a rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.compare_result(out_item_o);
  end

  // End the run if nothing moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("console_line_editor: mismatch");
      $finish;
    end
  end

  initial begin
    board       = new();
    steady      = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed keystrokes on the reset key codes.
    // Every edit on an empty line except insert is blocked or a newline.
    send_item(key_item(BACKSPACE_KEY_RST));
    send_item(key_item(DELETE_KEY_RST));
    send_item(key_item(LEFT_KEY_RST));
    send_item(key_item(RIGHT_KEY_RST));
    send_item(key_item(NEWLINE_KEY_RST));
    // Extreme codes go in as plain characters.
    send_item(key_item(8'h00));
    send_item(key_item(8'hFF));
    send_item(key_item(8'h41));
    send_item(key_item(LEFT_KEY_RST));
    send_item(key_item(LEFT_KEY_RST));
    // Insert in the middle shifts the tail.
    send_item(key_item(8'h42));
    send_item(read_item('0));
    send_item(read_item(IDX_W'(board.line_len - 1)));
    // Removals in the middle of the line.
    send_item(key_item(DELETE_KEY_RST));
    send_item(key_item(BACKSPACE_KEY_RST));
    repeat (3) send_item(key_item(RIGHT_KEY_RST));
    // Delete at the end of the line is blocked.
    send_item(key_item(DELETE_KEY_RST));
    send_item(key_item(NEWLINE_KEY_RST));
    // A read ignores its key code, which is random here.
    send_item(read_item('0));

    // Grow the line, then edit at its start so the whole line shifts.
    while (board.cursor_pos < board.line_len) send_item(key_item(board.key_reg[CFG_RIGHT]));
    repeat (24) send_item(key_item(plain_char()));
    send_item(read_item(IDX_W'(board.line_len - 1)));
    while (board.cursor_pos > 0) send_item(key_item(board.key_reg[CFG_LEFT]));
    send_item(key_item(plain_char()));
    send_item(key_item(board.key_reg[CFG_BACKSPACE]));
    send_item(read_item('0));
    send_item(read_item(IDX_W'(board.written_span - 1)));
    // Shrink from the line start so each removal moves the whole tail.
    while (board.line_len > 6) send_item(key_item(board.key_reg[CFG_DELETE]));

    // All keys equal: priority order decides, low and high extremes.
    load_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    run_random(70);
    load_keys(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_random(70);
    // Random key codes, back to back with no gaps or stalls.
    load_keys(KEY_W'($urandom), KEY_W'($urandom), KEY_W'($urandom),
              KEY_W'($urandom), KEY_W'($urandom));
    steady = 1'b1;
    run_random(110);
    steady = 1'b0;
    // Partial overlaps: backspace shadows delete, left shadows right.
    begin
      logic [KEY_W-1:0] erase_code;
      logic [KEY_W-1:0] move_code;
      erase_code = KEY_W'($urandom);
      move_code  = KEY_W'($urandom);
      load_keys(KEY_W'($urandom), erase_code, erase_code, move_code, move_code);
    end
    run_random(110);
    load_keys(NEWLINE_KEY_RST, BACKSPACE_KEY_RST, DELETE_KEY_RST, LEFT_KEY_RST,
              RIGHT_KEY_RST);
    run_random(125);

    drain_results();
    $display("Ran %0d items, checked %0d results over %0d key settings, edits at line start",
             board.items_seen, board.results_seen, key_settings);
    $display("inserts %0d, dropped %0d, removals %0d, moves %0d, blocked %0d,",
             board.inserts, board.drops, board.removals, board.moves, board.blocked);
    $display("newlines %0d, reads %0d", board.newlines, board.reads);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("console_line_editor: match");
    end else begin
      $display("console_line_editor: mismatch");
    end
    $finish;
  end

endmodule
